// File: rtl/core/ats_pkg.sv
package ats_pkg;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_LENGTH = 3'd0;
    localparam t_kind KIND_FORMAT = 3'd1;
    localparam t_kind KIND_TA     = 3'd2;
    localparam t_kind KIND_TB     = 3'd3;
    localparam t_kind KIND_TC     = 3'd4;
    localparam t_kind KIND_HIST   = 3'd5;
    localparam t_kind KIND_BEYOND = 3'd6;

    localparam int FMT_TA_BIT  = 4;
    localparam int FMT_TB_BIT  = 5;
    localparam int FMT_TC_BIT  = 6;
    localparam int FMT_RFU_BIT = 7;

    localparam logic [7:0] MAX_FRAME_BYTES = 8'd255;
    localparam logic [7:0] MIN_FRAME_BYTES = 8'd2;

    typedef struct packed {
        logic [7:0] byte_out;
        t_kind      byte_kind;
        logic       frame_done;
        logic       frame_status;
        logic [3:0] max_frame_code;
        logic       has_ta;
        logic       has_tb;
        logic       has_tc;
        logic [7:0] ta_value;
        logic [7:0] tb_value;
        logic [7:0] tc_value;
        logic [7:0] historical_count;
    } t_result;

endpackage

// File: rtl/core/answer_to_select_parser.sv
// answer-to-select frame parser
//
// input channel: i_rx_byte and i_end_of_frame with i_valid; o_stall holds the
// sender. a word is taken at a rising edge with i_valid high and o_stall low.
// output channel: one result word per input word on o_valid, held by i_stall.
// o_frame_done marks the result of the last byte of a frame; the decoded
// fields are then valid if o_frame_status is low, otherwise they read as zero.
//
// a word taken at an edge is written to the output register and shows at the
// outputs after that edge. throughput: one word per clock while i_stall is
// low, set by the single output register; the next word is taken in the same
// cycle that the current result is taken.
// when the receiver stalls, the result stays in the output register and
// o_stall rises, so no further word is taken until the result is gone.
// reset (synchronous, i_rst_n low) empties the output register and clears the
// frame state: byte count, overflow flag, length, format and interface bytes.
// the frame state also clears itself after the last byte of each frame.
module answer_to_select_parser
    import ats_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_end_of_frame,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_byte_kind,
    output logic       o_frame_done,
    output logic       o_frame_status,
    output logic [3:0] o_max_frame_code,
    output logic       o_has_ta,
    output logic       o_has_tb,
    output logic       o_has_tc,
    output logic [7:0] o_ta_value,
    output logic [7:0] o_tb_value,
    output logic [7:0] o_tc_value,
    output logic [7:0] o_historical_count
);

    logic [7:0] r_byte_count, n_byte_count;
    logic       r_ovf, n_ovf;
    logic [7:0] r_len, n_len;
    logic [7:0] r_fmt, n_fmt;
    logic [7:0] r_ta, n_ta;
    logic [7:0] r_tb, n_tb;
    logic [7:0] r_tc, n_tc;
    logic       r_out_valid;
    t_result    r_res, n_res;

    logic       in_acc;
    logic       f_ta, f_tb, f_tc;
    logic [1:0] nif;
    logic [7:0] slot_tb, slot_tc, min_size;
    logic       err;
    t_kind      kind;

    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        n_byte_count = r_byte_count;
        n_ovf        = r_ovf;
        n_len        = r_len;
        n_fmt        = r_fmt;
        n_ta         = r_ta;
        n_tb         = r_tb;
        n_tc         = r_tc;
        f_ta         = r_fmt[FMT_TA_BIT];
        f_tb         = r_fmt[FMT_TB_BIT];
        f_tc         = r_fmt[FMT_TC_BIT];
        slot_tb      = 8'd2 + {7'd0, f_ta};
        slot_tc      = slot_tb + {7'd0, f_tb};
        kind         = KIND_HIST;

        if (r_ovf || r_byte_count == MAX_FRAME_BYTES) begin
            n_ovf = 1'b1;
            kind  = KIND_BEYOND;
        end else begin
            n_byte_count = r_byte_count + 8'd1;
            if (r_byte_count == 8'd0) begin
                kind  = KIND_LENGTH;
                n_len = i_rx_byte;
            end else if (r_byte_count == 8'd1) begin
                kind  = KIND_FORMAT;
                n_fmt = i_rx_byte;
            end else if (f_ta && r_byte_count == 8'd2) begin
                kind = KIND_TA;
                n_ta = i_rx_byte;
            end else if (f_tb && r_byte_count == slot_tb) begin
                kind = KIND_TB;
                n_tb = i_rx_byte;
            end else if (f_tc && r_byte_count == slot_tc) begin
                kind = KIND_TC;
                n_tc = i_rx_byte;
            end
        end

        nif = {1'b0, n_fmt[FMT_TA_BIT]} + {1'b0, n_fmt[FMT_TB_BIT]}
            + {1'b0, n_fmt[FMT_TC_BIT]};
        min_size = MIN_FRAME_BYTES + {6'd0, nif};
        err = n_ovf || (n_byte_count < MIN_FRAME_BYTES) || (n_len != n_byte_count)
            || (n_byte_count < min_size) || n_fmt[FMT_RFU_BIT];

        n_res           = '0;
        n_res.byte_out  = i_rx_byte;
        n_res.byte_kind = kind;
        if (i_end_of_frame) begin
            n_res.frame_done   = 1'b1;
            n_res.frame_status = err;
            if (!err) begin
                n_res.max_frame_code   = n_fmt[3:0];
                n_res.has_ta           = n_fmt[FMT_TA_BIT];
                n_res.has_tb           = n_fmt[FMT_TB_BIT];
                n_res.has_tc           = n_fmt[FMT_TC_BIT];
                n_res.ta_value         = n_fmt[FMT_TA_BIT] ? n_ta : 8'd0;
                n_res.tb_value         = n_fmt[FMT_TB_BIT] ? n_tb : 8'd0;
                n_res.tc_value         = n_fmt[FMT_TC_BIT] ? n_tc : 8'd0;
                n_res.historical_count = n_byte_count - min_size;
            end
            n_byte_count = 8'd0;
            n_ovf        = 1'b0;
            n_len        = 8'd0;
            n_fmt        = 8'd0;
            n_ta         = 8'd0;
            n_tb         = 8'd0;
            n_tc         = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 8'd0;
            r_ovf        <= 1'b0;
            r_len        <= 8'd0;
            r_fmt        <= 8'd0;
            r_ta         <= 8'd0;
            r_tb         <= 8'd0;
            r_tc         <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_byte_count <= n_byte_count;
                r_ovf        <= n_ovf;
                r_len        <= n_len;
                r_fmt        <= n_fmt;
                r_ta         <= n_ta;
                r_tb         <= n_tb;
                r_tc         <= n_tc;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_byte_out         = r_res.byte_out;
    assign o_byte_kind        = r_res.byte_kind;
    assign o_frame_done       = r_res.frame_done;
    assign o_frame_status     = r_res.frame_status;
    assign o_max_frame_code   = r_res.max_frame_code;
    assign o_has_ta           = r_res.has_ta;
    assign o_has_tb           = r_res.has_tb;
    assign o_has_tc           = r_res.has_tc;
    assign o_ta_value         = r_res.ta_value;
    assign o_tb_value         = r_res.tb_value;
    assign o_tc_value         = r_res.tc_value;
    assign o_historical_count = r_res.historical_count;

    // frame state starts over after the last byte
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_frame) |=> (r_byte_count == 8'd0 && !r_ovf && r_fmt == 8'd0))
        else $error("frame state not cleared after last byte");

    // count advances by one per byte until it saturates
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_end_of_frame && !r_ovf && r_byte_count != MAX_FRAME_BYTES)
        |=> (r_byte_count == $past(r_byte_count) + 8'd1))
        else $error("byte count did not advance");

    // a word beyond the frame limit always ends in a parse error
    a_beyond_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done && o_byte_kind == KIND_BEYOND) |-> o_frame_status)
        else $error("overlong frame reported ok");

    // decoded fields stay zero unless a clean frame ends
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (!o_frame_done || o_frame_status))
        |-> (o_max_frame_code == 4'd0 && !o_has_ta && !o_has_tb && !o_has_tc
             && o_historical_count == 8'd0))
        else $error("fields set without a clean frame end");

endmodule

// File: tb/tb_answer_to_select_parser.sv
`timescale 1ns / 1ps

module tb_answer_to_select_parser
    import ats_pkg::*;
;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_end_of_frame = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_byte_out;
    logic [2:0] o_byte_kind;
    logic       o_frame_done;
    logic       o_frame_status;
    logic [3:0] o_max_frame_code;
    logic       o_has_ta;
    logic       o_has_tb;
    logic       o_has_tc;
    logic [7:0] o_ta_value;
    logic [7:0] o_tb_value;
    logic [7:0] o_tc_value;
    logic [7:0] o_historical_count;

    answer_to_select_parser i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_rx_byte          (i_rx_byte),
        .i_end_of_frame     (i_end_of_frame),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_byte_out         (o_byte_out),
        .o_byte_kind        (o_byte_kind),
        .o_frame_done       (o_frame_done),
        .o_frame_status     (o_frame_status),
        .o_max_frame_code   (o_max_frame_code),
        .o_has_ta           (o_has_ta),
        .o_has_tb           (o_has_tb),
        .o_has_tc           (o_has_tc),
        .o_ta_value         (o_ta_value),
        .o_tb_value         (o_tb_value),
        .o_tc_value         (o_tc_value),
        .o_historical_count (o_historical_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // frame state of the predictor
    logic [7:0] seen_bytes = 8'd0;
    logic       too_long = 1'b0;
    logic [7:0] frame_len = 8'd0;
    logic [7:0] frame_fmt = 8'd0;
    logic [7:0] ta_byte = 8'd0;
    logic [7:0] tb_byte = 8'd0;
    logic [7:0] tc_byte = 8'd0;

    t_result pending_results[$];
    t_result want_r;
    t_result got_r;
    int      mismatches = 0;
    int      words_sent = 0;
    int      cycles = 0;
    bit      src_gaps_on = 1'b1;
    bit      sink_gaps_on = 1'b1;
    bit      hold_req = 1'b0;

    function automatic t_result predict_ats_byte(input logic [7:0] b, input logic eof);
        t_result r;
        t_kind   k;
        int      slot;
        int      n_if;
        int      size;
        bit      bad;
        r = '0;
        if (too_long || seen_bytes == MAX_FRAME_BYTES) begin
            too_long = 1'b1;
            k = KIND_BEYOND;
        end else begin
            if (seen_bytes == 8'd0) begin
                k = KIND_LENGTH;
                frame_len = b;
            end else if (seen_bytes == 8'd1) begin
                k = KIND_FORMAT;
                frame_fmt = b;
            end else begin
                k = KIND_HIST;
                slot = 2;
                if (frame_fmt[FMT_TA_BIT]) begin
                    if (seen_bytes == slot) k = KIND_TA;
                    slot++;
                end
                if (frame_fmt[FMT_TB_BIT] && k == KIND_HIST) begin
                    if (seen_bytes == slot) k = KIND_TB;
                    slot++;
                end
                if (frame_fmt[FMT_TC_BIT] && k == KIND_HIST) begin
                    if (seen_bytes == slot) k = KIND_TC;
                end
                case (k)
                    KIND_TA: ta_byte = b;
                    KIND_TB: tb_byte = b;
                    KIND_TC: tc_byte = b;
                    default: ;
                endcase
            end
            seen_bytes = seen_bytes + 8'd1;
        end
        r.byte_out = b;
        r.byte_kind = k;
        if (eof) begin
            size = seen_bytes;
            n_if = frame_fmt[FMT_TA_BIT] + frame_fmt[FMT_TB_BIT] + frame_fmt[FMT_TC_BIT];
            bad = too_long || size < MIN_FRAME_BYTES || frame_len != size ||
                  size < MIN_FRAME_BYTES + n_if || frame_fmt[FMT_RFU_BIT];
            r.frame_done = 1'b1;
            r.frame_status = bad;
            if (!bad) begin
                r.max_frame_code = frame_fmt[3:0];
                r.has_ta = frame_fmt[FMT_TA_BIT];
                r.has_tb = frame_fmt[FMT_TB_BIT];
                r.has_tc = frame_fmt[FMT_TC_BIT];
                r.ta_value = frame_fmt[FMT_TA_BIT] ? ta_byte : 8'd0;
                r.tb_value = frame_fmt[FMT_TB_BIT] ? tb_byte : 8'd0;
                r.tc_value = frame_fmt[FMT_TC_BIT] ? tc_byte : 8'd0;
                r.historical_count = 8'(size - MIN_FRAME_BYTES - n_if);
            end
            seen_bytes = 8'd0;
            too_long = 1'b0;
            frame_len = 8'd0;
            frame_fmt = 8'd0;
            ta_byte = 8'd0;
            tb_byte = 8'd0;
            tc_byte = 8'd0;
        end
        return r;
    endfunction

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eof);
        int gap;
        gap = pick_gap(src_gaps_on);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        i_end_of_frame <= eof;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_ats_byte(b, eof));
        words_sent++;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] fmt, input int n_words);
        logic [7:0] b;
        for (int i = 0; i < n_words; i++) begin
            if (i == 0) b = len;
            else if (i == 1) b = fmt;
            else b = 8'($urandom);
            send_word(b, i == n_words - 1);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
    endtask

    task automatic test_minimal_frames();
        send_word(8'h02, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'h02, 1'b0);
        send_word(8'h0f, 1'b1);
        wait_drained();
    endtask

    task automatic test_interface_bytes();
        // ta, tb and tc all present, one historical word
        send_word(8'h06, 1'b0);
        send_word(8'h75, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'ha5, 1'b0);
        send_word(8'h5a, 1'b1);
        // ta and tc only
        send_word(8'h04, 1'b0);
        send_word(8'h50, 1'b0);
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b1);
        wait_drained();
    endtask

    task automatic test_parse_errors();
        // single word frame
        send_word(8'hff, 1'b1);
        // length byte disagrees with the count
        send_word(8'h03, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h11, 1'b0);
        send_word(8'h22, 1'b1);
        // frame ends before the announced interface bytes
        send_word(8'h03, 1'b0);
        send_word(8'h30, 1'b0);
        send_word(8'h11, 1'b1);
        // reserved format bit
        send_word(8'h02, 1'b0);
        send_word(8'h80, 1'b1);
        wait_drained();
    endtask

    task automatic test_long_frames();
        send_frame(8'hff, 8'h70, 255);
        send_frame(8'hff, 8'h00, 256);
        send_frame(8'h2c, 8'h10, 300);
        wait_drained();
    endtask

    task automatic test_receiver_hold();
        bit saved_gaps;
        saved_gaps = src_gaps_on;
        src_gaps_on = 1'b0;
        hold_req = 1'b1;
        send_frame(8'h05, 8'h32, 5);
        send_frame(8'h02, 8'h08, 2);
        send_frame(8'h0a, 8'h70, 10);
        wait_drained();
        hold_req = 1'b0;
        src_gaps_on = saved_gaps;
    endtask

    task automatic test_random_frames();
        int         start;
        int         pick;
        int         n_if;
        int         size;
        int         n_noise;
        logic [7:0] fmt;
        start = words_sent;
        while (words_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0) begin
                src_gaps_on = $urandom_range(0, 2) != 0;
                sink_gaps_on = $urandom_range(0, 2) != 0;
            end
            fmt = 8'($urandom);
            fmt[FMT_RFU_BIT] = 1'b0;
            n_if = fmt[FMT_TA_BIT] + fmt[FMT_TB_BIT] + fmt[FMT_TC_BIT];
            size = 2 + n_if + (($urandom_range(0, 9) == 0) ? $urandom_range(7, 30)
                                                            : $urandom_range(0, 6));
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                send_frame(8'(size), fmt, size);
            end else if (pick == 13) begin
                send_frame(8'($urandom), fmt, size);
            end else if (pick == 14) begin
                fmt[FMT_RFU_BIT] = 1'b1;
                send_frame(8'(size), fmt, size);
            end else if (pick == 15) begin
                send_frame(8'(size), fmt, $urandom_range(1, size - 1));
            end else if (pick == 16) begin
                send_frame(8'(size), fmt, size + $urandom_range(1, 3));
            end else begin
                n_noise = $urandom_range(1, 8);
                for (int i = 0; i < n_noise; i++)
                    send_word(8'($urandom), $urandom_range(0, 3) == 0);
                send_word(8'($urandom), 1'b1);
            end
        end
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        wait_drained();
    endtask

    initial begin : sink_side
        int n;
        bit hold_seen;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                if (!hold_req) hold_seen = 1'b0;
                n = pick_gap(sink_gaps_on);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_r.byte_out = o_byte_out;
            got_r.byte_kind = o_byte_kind;
            got_r.frame_done = o_frame_done;
            got_r.frame_status = o_frame_status;
            got_r.max_frame_code = o_max_frame_code;
            got_r.has_ta = o_has_ta;
            got_r.has_tb = o_has_tb;
            got_r.has_tc = o_has_tc;
            got_r.ta_value = o_ta_value;
            got_r.tb_value = o_tb_value;
            got_r.tc_value = o_tc_value;
            got_r.historical_count = o_historical_count;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, actual 0x%0h", $time, got_r);
            end else begin
                want_r = pending_results.pop_front();
                compare_field("byte_out", want_r.byte_out, got_r.byte_out);
                compare_field("byte_kind", want_r.byte_kind, got_r.byte_kind);
                compare_field("frame_done", want_r.frame_done, got_r.frame_done);
                compare_field("frame_status", want_r.frame_status, got_r.frame_status);
                compare_field("max_frame_code", want_r.max_frame_code, got_r.max_frame_code);
                compare_field("has_ta", want_r.has_ta, got_r.has_ta);
                compare_field("has_tb", want_r.has_tb, got_r.has_tb);
                compare_field("has_tc", want_r.has_tc, got_r.has_tc);
                compare_field("ta_value", want_r.ta_value, got_r.ta_value);
                compare_field("tb_value", want_r.tb_value, got_r.tb_value);
                compare_field("tc_value", want_r.tc_value, got_r.tc_value);
                compare_field("historical_count", want_r.historical_count,
                              got_r.historical_count);
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_minimal_frames();
        test_interface_bytes();
        test_parse_errors();
        test_long_frames();
        test_receiver_hold();
        test_random_frames();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected result words never arrived", $time,
                     pending_results.size());
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ats_pkg.sv
rtl/core/answer_to_select_parser.sv
tb/tb_answer_to_select_parser.sv
